@@ design/trb_pkg.sv @@
// Shared types and constants for the tableau row bump insert block.
`timescale 1ns / 1ps

package trb_pkg;

  localparam int unsigned IN_W           = 16;
  localparam int unsigned OUT_W          = 16;
  localparam int unsigned ROW_MAX_DEF    = 64;
  localparam int unsigned VALUE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } trb_state_e;

  typedef struct packed {
    logic clear;
    logic sample;
  } trb_scan_t;

endpackage

@@ design/tableau_row_bump_insert.sv @@
// Top level of the tableau row bump insert block.
// A word keeps busy_o high through the scan state, which reads each stored entry, the drain
// state for the read register and the decide state, or the decide state alone on an empty
// row; a new word is accepted only in idle. done_o, registered from the decide state, rises
// on the return to idle; the next word may start while it is high, and it cannot be stalled.
// Reset clears the row length to zero; the row storage itself is not cleared.
`timescale 1ns / 1ps

module tableau_row_bump_insert
  import trb_pkg::*;
#(
  parameter int unsigned ROW_MAX    = ROW_MAX_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [IN_W-1:0]  new_value_i,
  output logic             done_o,
  output logic             bumped_valid_o,
  output logic [OUT_W-1:0] bumped_value_o,
  output logic             row_full_o
);

  localparam int unsigned IDX_W = $clog2(ROW_MAX);

  trb_scan_t             scan;
  logic [VALUE_BITS-1:0] value;
  logic [IDX_W-1:0]      entry_idx;
  logic                  have;
  logic [VALUE_BITS-1:0] best;
  logic [IDX_W-1:0]      best_idx;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [IDX_W-1:0]      raddr;
  logic [VALUE_BITS-1:0] rdata;

  trb_ctrl #(
    .ROW_MAX    (ROW_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .new_value_i    (new_value_i),
    .done_o         (done_o),
    .bumped_valid_o (bumped_valid_o),
    .bumped_value_o (bumped_value_o),
    .row_full_o     (row_full_o),
    .scan_o         (scan),
    .value_o        (value),
    .entry_idx_o    (entry_idx),
    .have_i         (have),
    .best_i         (best),
    .best_idx_i     (best_idx),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .raddr_o        (raddr)
  );

  trb_best #(
    .ROW_MAX    (ROW_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (scan),
    .value_i     (value),
    .entry_i     (rdata),
    .entry_idx_i (entry_idx),
    .have_o      (have),
    .best_o      (best),
    .best_idx_o  (best_idx)
  );

  trb_row_mem #(
    .DEPTH (ROW_MAX),
    .WIDTH (VALUE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

@@ design/trb_row_mem.sv @@
// Row storage with one write port and one registered read port.
`timescale 1ns / 1ps

module trb_row_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/trb_best.sv @@
// Compare unit that tracks the largest entry strictly below the new value.
`timescale 1ns / 1ps

module trb_best
  import trb_pkg::*;
#(
  parameter int unsigned ROW_MAX    = ROW_MAX_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned IDX_W     = $clog2(ROW_MAX)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trb_scan_t             scan_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] entry_i,
  input  logic [IDX_W-1:0]      entry_idx_i,
  output logic                  have_o,
  output logic [VALUE_BITS-1:0] best_o,
  output logic [IDX_W-1:0]      best_idx_o
);

  logic                  have_q, have_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  take;

  assign take = (entry_i < value_i) && (!have_q || (entry_i > best_q));

  always_comb begin
    have_d = have_q;
    best_d = best_q;
    idx_d  = idx_q;
    if (scan_i.clear) begin
      have_d = 1'b0;
      best_d = '0;
      idx_d  = '0;
    end else if (scan_i.sample && take) begin
      have_d = 1'b1;
      best_d = entry_i;
      idx_d  = entry_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    idx_q  <= idx_d;
  end

  assign have_o     = have_q;
  assign best_o     = best_q;
  assign best_idx_o = idx_q;

endmodule

@@ design/trb_ctrl.sv @@
// Sequencer that scans the row, decides between bump, append and drop on a full row, and drives the result.
`timescale 1ns / 1ps

module trb_ctrl
  import trb_pkg::*;
#(
  parameter int unsigned ROW_MAX    = ROW_MAX_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned IDX_W     = $clog2(ROW_MAX),
  localparam int unsigned LEN_W     = $clog2(ROW_MAX + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [IN_W-1:0]       new_value_i,
  output logic                  done_o,
  output logic                  bumped_valid_o,
  output logic [OUT_W-1:0]      bumped_value_o,
  output logic                  row_full_o,
  output trb_scan_t             scan_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [IDX_W-1:0]      entry_idx_o,
  input  logic                  have_i,
  input  logic [VALUE_BITS-1:0] best_i,
  input  logic [IDX_W-1:0]      best_idx_i,
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o,
  output logic [VALUE_BITS-1:0] wdata_o,
  output logic [IDX_W-1:0]      raddr_o
);

  trb_state_e            state_q, state_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]      data_idx_q;
  logic [LEN_W-1:0]      len_q, len_d;
  logic                  rd_vld_q, rd_en;
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic                  done_q, done_d;
  logic                  bvld_q, bvld_d;
  logic [OUT_W-1:0]      bval_q, bval_d;
  logic                  full_q, full_d;
  logic                  last_rd;

  assign last_rd = (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;

  always_comb begin
    state_d       = state_q;
    rd_idx_d      = rd_idx_q;
    len_d         = len_q;
    v_d           = v_q;
    rd_en         = 1'b0;
    scan_o.clear  = 1'b0;
    scan_o.sample = rd_vld_q;
    we_o          = 1'b0;
    waddr_o       = '0;
    done_d        = 1'b0;
    bvld_d        = 1'b0;
    bval_d        = '0;
    full_d        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          v_d          = VALUE_BITS'(new_value_i);
          scan_o.clear = 1'b1;
          rd_idx_d     = '0;
          state_d      = (len_q == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (last_rd) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (have_i && (best_i != '0)) begin
          we_o    = 1'b1;
          waddr_o = best_idx_i;
          bvld_d  = 1'b1;
          bval_d  = OUT_W'(best_i);
        end else if (len_q != LEN_W'(ROW_MAX)) begin
          we_o    = 1'b1;
          waddr_o = len_q[IDX_W-1:0];
          len_d   = len_q + LEN_W'(1);
        end else begin
          full_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      rd_vld_q <= rd_en;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    data_idx_q <= rd_idx_q;
    v_q        <= v_d;
    bvld_q     <= bvld_d;
    bval_q     <= bval_d;
    full_q     <= full_d;
  end

  assign value_o        = v_q;
  assign entry_idx_o    = data_idx_q;
  assign wdata_o        = v_q;
  assign raddr_o        = rd_idx_q;
  assign busy_o         = state_q != ST_IDLE;
  assign done_o         = done_q;
  assign bumped_valid_o = bvld_q;
  assign bumped_value_o = bval_q;
  assign row_full_o     = full_q;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the tableau row bump insert block.
`timescale 1ns / 1ps

module tb;
  import trb_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] value;
    logic             full;
  } bump_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [IN_W-1:0]  new_value_i;
  logic             done_o;
  logic             bumped_valid_o;
  logic [OUT_W-1:0] bumped_value_o;
  logic             row_full_o;

  logic [VALUE_BITS_DEF-1:0] row_mirror [ROW_MAX_DEF];
  int unsigned               row_len_mirror;
  bump_result_t              expected_results [$];
  int unsigned               failures;
  int unsigned               n_inserted;
  int unsigned               n_bumped;
  int unsigned               n_appended;
  int unsigned               n_dropped;

  tableau_row_bump_insert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .new_value_i    (new_value_i),
    .done_o         (done_o),
    .bumped_valid_o (bumped_valid_o),
    .bumped_value_o (bumped_value_o),
    .row_full_o     (row_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The row mirror tracks every accepted word and queues the result it must cause.
  task automatic predict_insert(input logic [IN_W-1:0] v);
    bump_result_t              r;
    bit                        found;
    logic [VALUE_BITS_DEF-1:0] best;
    int unsigned               best_idx;
    found    = 1'b0;
    best     = '0;
    best_idx = 0;
    r        = '0;
    for (int unsigned i = 0; i < row_len_mirror; i++) begin
      if (row_mirror[i] < v && (!found || row_mirror[i] > best)) begin
        found    = 1'b1;
        best     = row_mirror[i];
        best_idx = i;
      end
    end
    if (found && best != '0) begin
      row_mirror[best_idx] = v;
      r.valid = 1'b1;
      r.value = best;
      n_bumped++;
    end else if (row_len_mirror < ROW_MAX_DEF) begin
      row_mirror[row_len_mirror] = v;
      row_len_mirror++;
      n_appended++;
    end else begin
      r.full = 1'b1;
      n_dropped++;
    end
    n_inserted++;
    expected_results.push_back(r);
  endtask

  // Called at a rising edge; leaves start high so that back-to-back words need no gap.
  task automatic send_word(input logic [IN_W-1:0] v);
    start_i     <= 1'b1;
    new_value_i <= v;
    do @(posedge clk_i); while (busy_o);
    predict_insert(v);
  endtask

  task automatic idle_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic test_empty_row();
    send_word(16'h1234);
    send_word(16'h1234);
  endtask

  task automatic test_tie_break();
    send_word(16'h2000);
    send_word(16'h3000);
    send_word(16'h1235);
  endtask

  task automatic test_zero_candidate();
    send_word(16'h0000);
    send_word(16'h0001);
    send_word(16'h0002);
  endtask

  task automatic test_extreme_values();
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_word(16'h5555);
    send_word(16'hAAAA);
    send_word(16'h0001);
  endtask

  // Mixes zeros and values at or below the smallest nonzero entry, which grow the row
  // and later hit the full case, with repeats of stored entries and uniform values.
  task automatic test_random_inserts(input int unsigned count, input int unsigned idle_pct);
    logic [IN_W-1:0] v;
    logic [IN_W-1:0] min_nz;
    int unsigned     pick;
    for (int unsigned n = 0; n < count; n++) begin
      min_nz = '1;
      for (int unsigned i = 0; i < row_len_mirror; i++) begin
        if (row_mirror[i] != '0 && row_mirror[i] < min_nz) min_nz = row_mirror[i];
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        v = '0;
      end else if (pick < 37) begin
        v = IN_W'($urandom_range(int'(min_nz)));
      end else if (pick < 47 && row_len_mirror != 0) begin
        v = row_mirror[$urandom_range(row_len_mirror - 1)];
      end else if (pick < 50) begin
        v = '1;
      end else begin
        v = IN_W'($urandom);
      end
      send_word(v);
      idle_gap(idle_pct);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    bump_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("Result word with none expected: bumped_valid=%0b bumped_value=%h row_full=%0b",
               bumped_valid_o, bumped_value_o, row_full_o);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (bumped_valid_o !== want.valid) begin
          $error("bumped_valid: expected %0b, actual %0b", want.valid, bumped_valid_o);
          failures++;
        end
        if (bumped_value_o !== want.value) begin
          $error("bumped_value: expected %h, actual %h", want.value, bumped_value_o);
          failures++;
        end
        if (row_full_o !== want.full) begin
          $error("row_full: expected %0b, actual %0b", want.full, row_full_o);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    new_value_i    = '0;
    row_len_mirror = 0;
    failures       = 0;
    n_inserted     = 0;
    n_bumped       = 0;
    n_appended     = 0;
    n_dropped      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_row();
    test_tie_break();
    test_zero_candidate();
    test_extreme_values();
    test_random_inserts(200, 0);
    test_random_inserts(200, 52);
    test_random_inserts(200, 9);

    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (ROW_MAX_DEF + 4) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      failures++;
    end
    $display("Inserted %0d words: %0d bumped an entry, %0d appended, %0d dropped on a full row.",
             n_inserted, n_bumped, n_appended, n_dropped);
    $display("Final row length %0d of %0d.", row_len_mirror, ROW_MAX_DEF);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/trb_pkg.sv
design/trb_row_mem.sv
design/trb_best.sv
design/trb_ctrl.sv
design/tableau_row_bump_insert.sv
bench/tb.sv
